// File: src/nine_segment_digit_pixel_test_assert.svh
// Assertion macros shared by the digit pixel test RTL.
`ifndef NINE_SEGMENT_DIGIT_PIXEL_TEST_ASSERT_SVH
`define NINE_SEGMENT_DIGIT_PIXEL_TEST_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked only while out of reset.
`define NSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define NSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define NSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define NSD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: src/nsd_pkg.sv
// Shared constants, register codes and segment table for the digit pixel test.
`default_nettype none

package nsd_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int COLOR_W         = 8;
  localparam int DIGIT_W         = 4;
  localparam int NUM_SEG         = 9;
  localparam int CFG_INDEX_W     = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_LEFT    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_TOP     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_WIDTH   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_HEIGHT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RED_LEVEL   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GREEN_LEVEL = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_BLUE_LEVEL  = 3'd6;

  localparam int BOX_LEFT_RST   = 0;
  localparam int BOX_TOP_RST    = 0;
  localparam int BOX_WIDTH_RST  = 16;
  localparam int BOX_HEIGHT_RST = 32;
  localparam logic [COLOR_W-1:0] LEVEL_RST = 8'd255;

  // x / 10 == (x * 52429) >> 19 holds exactly for every x below 2^16.
  localparam int               DIV10_MUL_W = 16;
  localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
  localparam int               DIV10_SHIFT = 19;

  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = 4'd10;

  // Bit k lights segment k: top, middle, bottom, left upper, left lower,
  // centre upper, centre lower, right upper, right lower.
  function automatic logic [NUM_SEG-1:0] seg_mask(input logic [DIGIT_W-1:0] digit);
    logic [NUM_SEG-1:0] m;
    case (digit)
      4'd0:    m = 9'b110011101;
      4'd1:    m = 9'b001100000;
      4'd2:    m = 9'b010010111;
      4'd3:    m = 9'b110000111;
      4'd4:    m = 9'b110001010;
      4'd5:    m = 9'b100001111;
      4'd6:    m = 9'b100011111;
      4'd7:    m = 9'b110000001;
      4'd8:    m = 9'b110011111;
      4'd9:    m = 9'b110001011;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/nsd_if.sv
// Valid/ready channel interfaces for pixel queries and pixel results.
`default_nettype none

interface nsd_pix_if #(
  parameter int COORD_WIDTH = nsd_pkg::COORD_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic [nsd_pkg::DIGIT_W-1:0]      digit_value;
  logic [COORD_WIDTH-1:0]           pixel_x;
  logic [COORD_WIDTH-1:0]           pixel_y;

  modport source (output valid, digit_value, pixel_x, pixel_y, input ready);
  modport sink   (input valid, digit_value, pixel_x, pixel_y, output ready);
endinterface

interface nsd_res_if;
  logic                             valid;
  logic                             ready;
  logic                             pixel_lit;
  logic [nsd_pkg::COLOR_W-1:0]      out_red;
  logic [nsd_pkg::COLOR_W-1:0]      out_green;
  logic [nsd_pkg::COLOR_W-1:0]      out_blue;

  modport source (output valid, pixel_lit, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, pixel_lit, out_red, out_green, out_blue, output ready);
endinterface

`default_nettype wire

// File: src/nine_segment_digit_pixel_test.sv
// Top level of the nine-segment digit pixel test.
//
// Each beat on in_pix carries a digit and one screen coordinate; each beat
// on out_res answers whether that pixel falls in a lit segment of the digit
// drawn in the configured box, with the configured colour when lit and zero
// otherwise. Exactly one result beat leaves for every query beat, in order.
// The user must write the box position, size and colour on the cfg_ port
// only while no query is in flight; the block itself does not enforce this.
// A box size write reaches the stroke width through its box register and
// then one registered stage. A query passes an input register, then the
// rectangle compares into the output register. One beat is accepted per
// cycle with the receiver ready. When out_res stalls, the output register
// holds its beat and the input register fills, so the pipe absorbs one more
// beat before in_pix.ready drops. Reset empties both stages and loads the
// default box (origin, 16 by 32) and a white colour.
`default_nettype none

`include "nine_segment_digit_pixel_test_assert.svh"

module nine_segment_digit_pixel_test #(
  parameter int COORD_WIDTH = nsd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  nsd_pix_if.sink                                 in_pix,
  nsd_res_if.source                               out_res,
  input  wire logic                               cfg_we,
  input  wire logic [nsd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [COORD_WIDTH-1:0]             cfg_wdata
);
  import nsd_pkg::*;

  localparam int SW = COORD_WIDTH + 3;

  logic [COORD_WIDTH-1:0] box_left_r, box_top_r, box_width_r, box_height_r;
  logic [COLOR_W-1:0]     red_level_r, green_level_r, blue_level_r;

  logic                   s1_valid_r;
  logic [DIGIT_W-1:0]     s1_digit_r;
  logic [COORD_WIDTH-1:0] s1_x_r, s1_y_r;

  logic                   out_valid_r;
  logic                   pixel_lit_r;
  logic [COLOR_W-1:0]     out_red_r, out_green_r, out_blue_r;

  logic                   en_out, en_s1;
  logic signed [SW-1:0]   x0 [NUM_SEG];
  logic signed [SW-1:0]   x1 [NUM_SEG];
  logic signed [SW-1:0]   y0 [NUM_SEG];
  logic signed [SW-1:0]   y1 [NUM_SEG];
  logic signed [SW-1:0]   px_s, py_s;
  logic [NUM_SEG-1:0]     mask, hit;
  logic                   lit_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_left_r    <= COORD_WIDTH'(BOX_LEFT_RST);
      box_top_r     <= COORD_WIDTH'(BOX_TOP_RST);
      box_width_r   <= COORD_WIDTH'(BOX_WIDTH_RST);
      box_height_r  <= COORD_WIDTH'(BOX_HEIGHT_RST);
      red_level_r   <= LEVEL_RST;
      green_level_r <= LEVEL_RST;
      blue_level_r  <= LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_LEFT:    box_left_r    <= cfg_wdata;
        REG_BOX_TOP:     box_top_r     <= cfg_wdata;
        REG_BOX_WIDTH:   box_width_r   <= cfg_wdata;
        REG_BOX_HEIGHT:  box_height_r  <= cfg_wdata;
        REG_RED_LEVEL:   red_level_r   <= cfg_wdata[COLOR_W-1:0];
        REG_GREEN_LEVEL: green_level_r <= cfg_wdata[COLOR_W-1:0];
        REG_BLUE_LEVEL:  blue_level_r  <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  nsd_geom #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_geom (
    .clk        (clk),
    .box_left   (box_left_r),
    .box_top    (box_top_r),
    .box_width  (box_width_r),
    .box_height (box_height_r),
    .x0         (x0),
    .x1         (x1),
    .y0         (y0),
    .y1         (y1)
  );

  // Two-stage pipe; each stage moves when the one after it can take a beat.
  assign en_out       = !out_valid_r || out_res.ready;
  assign en_s1        = !s1_valid_r || en_out;
  assign in_pix.ready = en_s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_valid_r <= in_pix.valid;
      end
      if (en_out) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1 && in_pix.valid) begin
      s1_digit_r <= in_pix.digit_value;
      s1_x_r     <= in_pix.pixel_x;
      s1_y_r     <= in_pix.pixel_y;
    end
  end

  // A segment with zero or negative length has its far bound at or before
  // its near bound, so the compares alone leave it dark.
  always_comb begin
    px_s = $signed({3'b000, s1_x_r});
    py_s = $signed({3'b000, s1_y_r});
    mask = (s1_digit_r < DIGIT_LIMIT) ? seg_mask(s1_digit_r) : '0;
    for (int k = 0; k < NUM_SEG; k++) begin
      hit[k] = mask[k] && (px_s >= x0[k]) && (px_s < x1[k])
               && (py_s >= y0[k]) && (py_s < y1[k]);
    end
    lit_nxt = |hit;
  end

  always_ff @(posedge clk) begin
    if (en_out && s1_valid_r) begin
      pixel_lit_r <= lit_nxt;
      out_red_r   <= lit_nxt ? red_level_r   : '0;
      out_green_r <= lit_nxt ? green_level_r : '0;
      out_blue_r  <= lit_nxt ? blue_level_r  : '0;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.pixel_lit = pixel_lit_r;
  assign out_res.out_red   = out_red_r;
  assign out_res.out_green = out_green_r;
  assign out_res.out_blue  = out_blue_r;

  `NSD_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid_r && !s1_valid_r, "pipe not empty after reset")
  `NSD_ASSERT(a_dark_is_black, clk, rst_n, out_valid_r && !pixel_lit_r |-> out_red_r == '0 && out_green_r == '0 && out_blue_r == '0, "unlit pixel carries colour")
  `NSD_ASSERT(a_lit_colour, clk, rst_n, out_valid_r && pixel_lit_r |-> out_red_r == red_level_r && out_green_r == green_level_r && out_blue_r == blue_level_r, "lit pixel colour differs from registers")
  `NSD_ASSERT(a_no_drop, clk, rst_n, s1_valid_r && out_valid_r && !out_res.ready |=> s1_valid_r && out_valid_r, "beat lost while output stalled")
  `NSD_ASSERT(a_bad_digit_dark, clk, rst_n, s1_valid_r && en_out && s1_digit_r >= DIGIT_LIMIT |=> !pixel_lit_r, "digit above nine lit a pixel")

endmodule

`default_nettype wire

// File: src/nsd_geom.sv
// Segment rectangle bounds derived from the digit box registers.
`default_nettype none

module nsd_geom #(
  parameter int COORD_WIDTH = nsd_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic [COORD_WIDTH-1:0]        box_left,
  input  wire logic [COORD_WIDTH-1:0]        box_top,
  input  wire logic [COORD_WIDTH-1:0]        box_width,
  input  wire logic [COORD_WIDTH-1:0]        box_height,
  output logic signed [COORD_WIDTH+2:0]      x0 [nsd_pkg::NUM_SEG],
  output logic signed [COORD_WIDTH+2:0]      x1 [nsd_pkg::NUM_SEG],
  output logic signed [COORD_WIDTH+2:0]      y0 [nsd_pkg::NUM_SEG],
  output logic signed [COORD_WIDTH+2:0]      y1 [nsd_pkg::NUM_SEG]
);
  import nsd_pkg::*;

  localparam int SW     = COORD_WIDTH + 3;
  localparam int PROD_W = COORD_WIDTH + DIV10_MUL_W;

  logic [COORD_WIDTH-1:0] min_wh;
  logic [PROD_W-1:0]      prod;
  logic [PROD_W-1:0]      quot;
  logic [COORD_WIDTH-1:0] lw_nxt;
  logic [COORD_WIDTH-1:0] lw_r;
  logic [COORD_WIDTH-1:0] w_minus_lw;

  logic signed [SW-1:0] l_s, t_s, w_s, h_s, lw_s, lw2_s, hh_s, lwh_s, xoff_s;
  logic signed [SW-1:0] xc_s, yup0, yup1, ylo0, ylo1, xh0, xh1, xr0, lr_s;

  // The stroke width only depends on the registers, so it is registered
  // ahead of use; the bounds below are short adds from it.
  always_comb begin
    min_wh = (box_width < box_height) ? box_width : box_height;
    prod   = PROD_W'(min_wh) * PROD_W'(DIV10_MUL);
    quot   = prod >> DIV10_SHIFT;
    lw_nxt = (quot[COORD_WIDTH-1:0] == '0) ? COORD_WIDTH'(1) : quot[COORD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    lw_r <= lw_nxt;
  end

  always_comb begin
    w_minus_lw = box_width - lw_r;
    l_s    = $signed({3'b000, box_left});
    t_s    = $signed({3'b000, box_top});
    w_s    = $signed({3'b000, box_width});
    h_s    = $signed({3'b000, box_height});
    lw_s   = $signed({3'b000, lw_r});
    lw2_s  = lw_s + lw_s;
    hh_s   = $signed({4'b0000, box_height[COORD_WIDTH-1:1]});
    lwh_s  = $signed({4'b0000, lw_r[COORD_WIDTH-1:1]});
    xoff_s = (box_width >= lw_r) ? $signed({4'b0000, w_minus_lw[COORD_WIDTH-1:1]}) : '0;
    xc_s   = l_s + xoff_s;
    lr_s   = l_s + w_s;
    xh0    = l_s + lw2_s;
    xh1    = lr_s - lw2_s;
    xr0    = lr_s - lw_s;
    yup0   = t_s + lw_s;
    yup1   = t_s + hh_s - lw_s;
    ylo0   = t_s + hh_s + lw_s;
    ylo1   = t_s + hh_s + hh_s - lw_s;

    x0[0] = xh0;  x1[0] = xh1;  y0[0] = t_s;                y1[0] = t_s + lw_s;
    x0[1] = xh0;  x1[1] = xh1;  y0[1] = t_s + hh_s - lwh_s; y1[1] = t_s + hh_s - lwh_s + lw_s;
    x0[2] = xh0;  x1[2] = xh1;  y0[2] = t_s + h_s - lw_s;   y1[2] = t_s + h_s;
    x0[3] = l_s;  x1[3] = l_s + lw_s;  y0[3] = yup0;  y1[3] = yup1;
    x0[4] = l_s;  x1[4] = l_s + lw_s;  y0[4] = ylo0;  y1[4] = ylo1;
    x0[5] = xc_s; x1[5] = xc_s + lw_s; y0[5] = yup0;  y1[5] = yup1;
    x0[6] = xc_s; x1[6] = xc_s + lw_s; y0[6] = ylo0;  y1[6] = ylo1;
    x0[7] = xr0;  x1[7] = lr_s;        y0[7] = yup0;  y1[7] = yup1;
    x0[8] = xr0;  x1[8] = lr_s;        y0[8] = ylo0;  y1[8] = ylo1;
  end

endmodule

`default_nettype wire

// File: dv/nsd_pixel_check.sv
// Watches the pixel query and result channels, predicts each pixel's shade and compares.
`timescale 1ns / 1ps

module nsd_pixel_check #(
  parameter int COORD_W = nsd_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  nsd_pix_if                              pix,
  nsd_res_if                              res,
  input  logic                            cfg_we,
  input  logic [nsd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]              cfg_wdata,
  output int                              mismatch_cnt,
  output int                              owed_cnt
);
  import nsd_pkg::*;

  typedef struct packed {
    logic               lit;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pix_shade_t;

  // Leftmost bit is the top bar, then middle, bottom, left upper, left lower,
  // center upper, center lower, right upper, right lower.
  localparam bit [0:8] LIT_SEGS [0:9] = '{
    9'b101110011, 9'b000001100, 9'b111010010, 9'b111000011, 9'b010100011,
    9'b111100001, 9'b111110001, 9'b100000011, 9'b111110011, 9'b110100011
  };

  logic [COORD_W-1:0] box_l, box_t, box_w, box_h;
  logic [COLOR_W-1:0] lvl_r, lvl_g, lvl_b;
  pix_shade_t         owed_pixels[$];

  function automatic pix_shade_t shade_pixel(input logic [DIGIT_W-1:0] digit,
                                             input logic [COORD_W-1:0] x_u,
                                             input logic [COORD_W-1:0] y_u);
    int         px, py, bl, bt, bw, bh, lw, hlen, vlen, xc;
    int         rx[9], ry[9], rw[9], rh[9];
    bit         hit;
    pix_shade_t shade;
    px = int'(x_u);
    py = int'(y_u);
    bl = int'(box_l);
    bt = int'(box_t);
    bw = int'(box_w);
    bh = int'(box_h);
    lw = ((bw < bh) ? bw : bh) / 10;
    if (lw < 1) lw = 1;
    hlen = bw - 4 * lw;
    vlen = bh / 2 - 2 * lw;
    xc = bl + ((bw >= lw) ? (bw - lw) / 2 : 0);
    rx[0] = bl + 2 * lw; ry[0] = bt;
    rx[1] = bl + 2 * lw; ry[1] = bt + bh / 2 - lw / 2;
    rx[2] = bl + 2 * lw; ry[2] = bt + bh - lw;
    rx[3] = bl;          rx[4] = bl;
    rx[5] = xc;          rx[6] = xc;
    rx[7] = bl + bw - lw; rx[8] = bl + bw - lw;
    for (int k = 0; k < 9; k++) begin
      rw[k] = (k < 3) ? hlen : lw;
      rh[k] = (k < 3) ? lw : vlen;
      // Odd strokes are the upper ones, even strokes the lower ones.
      if (k >= 3) ry[k] = (k % 2) ? bt + lw : bt + bh / 2 + lw;
    end
    hit = 1'b0;
    if (digit < 10) begin
      for (int k = 0; k < 9; k++) begin
        if (LIT_SEGS[digit][k] && px >= rx[k] && px < rx[k] + rw[k] &&
            py >= ry[k] && py < ry[k] + rh[k])
          hit = 1'b1;
      end
    end
    shade.lit   = hit;
    shade.red   = hit ? lvl_r : '0;
    shade.green = hit ? lvl_g : '0;
    shade.blue  = hit ? lvl_b : '0;
    return shade;
  endfunction

  always @(posedge clk) begin
    pix_shade_t want, got;
    if (!rst_n) begin
      box_l = COORD_W'(BOX_LEFT_RST);
      box_t = COORD_W'(BOX_TOP_RST);
      box_w = COORD_W'(BOX_WIDTH_RST);
      box_h = COORD_W'(BOX_HEIGHT_RST);
      lvl_r = LEVEL_RST;
      lvl_g = LEVEL_RST;
      lvl_b = LEVEL_RST;
      owed_pixels.delete();
      mismatch_cnt = 0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{res.pixel_lit, res.out_red, res.out_green, res.out_blue};
        if (owed_pixels.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result beat with no query waiting: lit=%0d rgb=%02h%02h%02h",
                     $realtime, got.lit, got.red, got.green, got.blue);
        end else begin
          want = owed_pixels.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"%0t: pixel mismatch: expected lit=%0d rgb=%02h%02h%02h,",
                        " got lit=%0d rgb=%02h%02h%02h"},
                       $realtime, want.lit, want.red, want.green, want.blue,
                       got.lit, got.red, got.green, got.blue);
          end
        end
      end
      if (pix.valid && pix.ready)
        owed_pixels.push_back(shade_pixel(pix.digit_value, pix.pixel_x, pix.pixel_y));
      if (cfg_we) begin
        case (cfg_index)
          REG_BOX_LEFT:    box_l = cfg_wdata;
          REG_BOX_TOP:     box_t = cfg_wdata;
          REG_BOX_WIDTH:   box_w = cfg_wdata;
          REG_BOX_HEIGHT:  box_h = cfg_wdata;
          REG_RED_LEVEL:   lvl_r = cfg_wdata[COLOR_W-1:0];
          REG_GREEN_LEVEL: lvl_g = cfg_wdata[COLOR_W-1:0];
          REG_BLUE_LEVEL:  lvl_b = cfg_wdata[COLOR_W-1:0];
          default: ;
        endcase
      end
    end
    owed_cnt = owed_pixels.size();
  end

endmodule

// File: dv/nine_segment_digit_pixel_test_tb.sv
// Top of the digit pixel test bench: clock, reset, box settings, pixel queries and verdict.
`timescale 1ns / 1ps

module nine_segment_digit_pixel_test_tb;
  import nsd_pkg::*;

  localparam int COORD_W = COORD_WIDTH_DEF;
  // Index past the last register; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COORD_W-1:0]     cfg_wdata;
  int                     mismatch_cnt;
  int                     owed_cnt;
  int                     beats_sent;

  nsd_pix_if #(.COORD_WIDTH(COORD_W)) pix_ch ();
  nsd_res_if res_ch ();

  nine_segment_digit_pixel_test #(.COORD_WIDTH(COORD_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_ch),
    .out_res   (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  nsd_pixel_check #(.COORD_W(COORD_W)) pixel_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .pix          (pix_ch),
    .res          (res_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatch_cnt (mismatch_cnt),
    .owed_cnt     (owed_cnt)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: stretches of varying readiness, and long hold-offs that let
  // the pipe fill while queries keep coming.
  initial begin : drain_side
    int  seg_len;
    int  ready_pct;
    bit  held_once;
    res_ch.ready = 1'b0;
    held_once = 1'b0;
    forever begin
      if ((!held_once && beats_sent > 300) || $urandom_range(0, 24) == 0) begin
        held_once = 1'b1;
        seg_len = int'($urandom_range(150, 400));
        ready_pct = 0;
      end else begin
        seg_len = int'($urandom_range(10, 120));
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 75;
          2:       ready_pct = 50;
          default: ready_pct = 25;
        endcase
      end
      repeat (seg_len) begin
        @(negedge clk);
        res_ch.ready = ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  task automatic offer_pixel(input logic [DIGIT_W-1:0] digit,
                             input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y,
                             input int gap);
    @(negedge clk);
    if (gap > 0) begin
      pix_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid       = 1'b1;
    pix_ch.digit_value = digit;
    pix_ch.pixel_x     = x;
    pix_ch.pixel_y     = y;
    do @(posedge clk); while (!pix_ch.ready);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [COORD_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_wdata = data;
    @(negedge clk);
  endtask

  // Settings change only with the pipe empty; the wait after the writes lets
  // the stroke width follow a new box size.
  task automatic apply_box(input logic [COORD_W-1:0] l, t, w, h, r, g, b);
    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (owed_cnt != 0) @(negedge clk);
    write_reg(REG_BOX_LEFT, l);
    write_reg(REG_BOX_TOP, t);
    write_reg(REG_BOX_WIDTH, w);
    write_reg(REG_BOX_HEIGHT, h);
    write_reg(REG_RED_LEVEL, r);
    write_reg(REG_GREEN_LEVEL, g);
    write_reg(REG_BLUE_LEVEL, b);
    write_reg(REG_UNUSED, COORD_W'($urandom));
    cfg_we = 1'b0;
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [COORD_W-1:0] bl, bt, bw, bh, cr, cg, cb, qx, qy;
    logic [DIGIT_W-1:0] dg;
    int                 burst_left;
    int                 gap_len;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.digit_value = '0;
    pix_ch.pixel_x     = '0;
    pix_ch.pixel_y     = '0;
    beats_sent         = 0;
    // Counting rising edges keeps the reset length in full clock periods even if
    // the clock's first assignment registers as a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Default 16 by 32 box at the origin: every segment, every digit,
    // segment edges, corners and digits above nine.
    offer_pixel(4'd8, 12'd5, 12'd0, 0);
    offer_pixel(4'd8, 12'd5, 12'd16, 0);
    offer_pixel(4'd8, 12'd5, 12'd31, 0);
    offer_pixel(4'd8, 12'd0, 12'd5, 0);
    offer_pixel(4'd8, 12'd0, 12'd20, 0);
    offer_pixel(4'd1, 12'd7, 12'd5, 0);
    offer_pixel(4'd1, 12'd7, 12'd20, 1);
    offer_pixel(4'd8, 12'd15, 12'd5, 0);
    offer_pixel(4'd8, 12'd15, 12'd20, 0);
    offer_pixel(4'd0, 12'd5, 12'd16, 0);
    offer_pixel(4'd2, 12'd0, 12'd0, 2);
    offer_pixel(4'd3, 12'd14, 12'd0, 0);
    offer_pixel(4'd4, 12'd15, 12'd5, 0);
    offer_pixel(4'd5, 12'd0, 12'd5, 0);
    offer_pixel(4'd6, 12'd0, 12'd20, 0);
    offer_pixel(4'd7, 12'd4095, 12'd4095, 0);
    offer_pixel(4'd9, 12'd5, 12'd16, 0);
    offer_pixel(4'd10, 12'd5, 12'd0, 0);
    offer_pixel(4'd15, 12'd5, 12'd0, 0);
    offer_pixel(4'd8, 12'd0, 12'd4095, 0);
    offer_pixel(4'd8, 12'd4095, 12'd0, 0);

    burst_left = 0;
    for (int phase = 0; phase < 12; phase++) begin
      cr = COORD_W'($urandom);
      cg = COORD_W'($urandom);
      cb = COORD_W'($urandom);
      case (phase)
        0: begin
          // Empty box: stroke width falls back to one, every length negative.
          bl = '0; bt = '0; bw = '0; bh = '0;
        end
        1: begin
          // Zero width with a normal height.
          bl = 12'd100; bt = 12'd50; bw = '0; bh = 12'd32;
        end
        2: begin
          bl = '1; bt = '1; bw = '1; bh = '1;
          cr = '0; cg = '0; cb = '0;
        end
        3: begin
          bl = '0; bt = '0; bw = '1; bh = '1;
          cr = '1; cg = '1; cb = '1;
        end
        4: begin
          bl = 12'd2000; bt = 12'd1000; bw = 12'd1; bh = 12'd1;
        end
        5: begin
          // Narrow and tall: stroke width rounds down to zero, then one.
          bl = COORD_W'($urandom); bt = COORD_W'($urandom); bw = 12'd9; bh = 12'd200;
        end
        default: begin
          bl = COORD_W'($urandom);
          bt = COORD_W'($urandom);
          bw = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom)
                                           : COORD_W'($urandom_range(1, 120));
          bh = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom)
                                           : COORD_W'($urandom_range(1, 120));
        end
      endcase
      apply_box(bl, bt, bw, bh, cr, cg, cb);

      for (int n = 0; n < 85; n++) begin
        if (burst_left == 0) begin
          burst_left = int'($urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 16));
          gap_len = int'($urandom_range(0, 7));
        end else begin
          gap_len = 0;
        end
        burst_left--;
        dg = DIGIT_W'(($urandom_range(0, 7) == 0) ? $urandom_range(10, 15)
                                                  : $urandom_range(0, 9));
        if ($urandom_range(0, 4) == 0) begin
          qx = COORD_W'($urandom);
          qy = COORD_W'($urandom);
        end else begin
          // Mostly inside the box or just around its edges.
          qx = COORD_W'(bl + $urandom_range(0, bw + 4) - 2);
          qy = COORD_W'(bt + $urandom_range(0, bh + 4) - 2);
        end
        offer_pixel(dg, qx, qy, gap_len);
      end
    end

    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (owed_cnt != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && owed_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
